// ===== hw/rtl/spq_pkg.sv =====
// shared types, sizes and codes for the sorted priority queue
package spq_pkg;

    localparam int DEPTH   = 64;
    localparam int TAG_W   = 8;
    localparam int PRI_W   = 16;
    localparam int OCC_W   = 7;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = ($clog2(DEPTH + 1) > OCC_W) ? $clog2(DEPTH + 1) : OCC_W;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                    valid;
        logic [TAG_W-1:0]        tag;
        logic signed [PRI_W-1:0] pri;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// one slot of the sorted chain: holds an entry, shifts left or right
module spq_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  spq_pkg::ctrl_t  ctrl,
    input  spq_pkg::entry_t left_entry,
    input  logic            left_keep,
    input  spq_pkg::entry_t right_entry,
    output spq_pkg::entry_t entry,
    output logic            keep
);

    spq_pkg::entry_t e_reg;
    spq_pkg::entry_t e_next;

    assign keep  = e_reg.valid && (e_reg.pri <= ctrl.new_entry.pri);
    assign entry = e_reg;

    always_comb begin
        e_next = e_reg;
        if (ctrl.enq) begin
            if (!keep) begin
                if (left_keep) begin
                    e_next       = ctrl.new_entry;
                    e_next.valid = 1'b1;
                end else begin
                    e_next = left_entry;
                end
            end
        end else if (ctrl.deq) begin
            e_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_reg <= '0;
        end else begin
            e_reg <= e_next;
        end
    end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// sorted priority queue top level: command decode, cell chain, result register
// result: an accepted request's result is registered and shows on m_tvalid in the next cycle
// throughput: one request per cycle while the result register is drained; every cell of the chain updates in that cycle
// s_tready stays high while the result register is empty or being drained
// reset clears the held count, the cell valid bits and the result valid flag
module sorted_priority_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command [0], tag [8:1], priority_req [24:9], zero fill
    input  logic [spq_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status [1:0], out_tag [9:2], out_priority [25:10], occupancy [32:26], zero fill
    output logic [spq_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int D = spq_pkg::DEPTH;

    logic                           s_acc;
    logic                           cmd;
    logic [spq_pkg::TAG_W-1:0]      in_tag;
    logic signed [spq_pkg::PRI_W-1:0] in_pri;
    logic                           full;
    logic                           empty;
    spq_pkg::ctrl_t                 ctrl;

    logic [spq_pkg::CNT_W-1:0]      count_reg;
    logic [spq_pkg::CNT_W-1:0]      count_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [spq_pkg::STAT_W-1:0]     status_reg;
    logic [spq_pkg::STAT_W-1:0]     status_next;
    logic [spq_pkg::TAG_W-1:0]      otag_reg;
    logic [spq_pkg::TAG_W-1:0]      otag_next;
    logic [spq_pkg::PRI_W-1:0]      opri_reg;
    logic [spq_pkg::PRI_W-1:0]      opri_next;

    spq_pkg::entry_t                cell_entry [D];
    logic                           cell_keep  [D];
    spq_pkg::entry_t                empty_entry;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign cmd      = s_tdata[0];
    assign in_tag   = s_tdata[8:1];
    assign in_pri   = s_tdata[24:9];

    assign full  = (count_reg == spq_pkg::CNT_W'(D));
    assign empty = (count_reg == '0);

    assign empty_entry = '0;

    always_comb begin
        ctrl                     = '0;
        ctrl.enq                 = s_acc && (cmd == spq_pkg::CMD_ENQ) && !full;
        ctrl.deq                 = s_acc && (cmd == spq_pkg::CMD_DEQ) && !empty;
        ctrl.new_entry.valid     = 1'b1;
        ctrl.new_entry.tag       = in_tag;
        ctrl.new_entry.pri       = in_pri;
    end

    genvar i;
    generate
        for (i = 0; i < D; i++) begin : g_cell
            if (i == 0 && D == 1) begin : g_only
                spq_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
                    .left_entry(empty_entry), .left_keep(1'b1),
                    .right_entry(empty_entry),
                    .entry(cell_entry[i]), .keep(cell_keep[i])
                );
            end else if (i == 0) begin : g_head
                spq_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
                    .left_entry(empty_entry), .left_keep(1'b1),
                    .right_entry(cell_entry[i+1]),
                    .entry(cell_entry[i]), .keep(cell_keep[i])
                );
            end else if (i == D - 1) begin : g_tail
                spq_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
                    .left_entry(cell_entry[i-1]), .left_keep(cell_keep[i-1]),
                    .right_entry(empty_entry),
                    .entry(cell_entry[i]), .keep(cell_keep[i])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl),
                    .left_entry(cell_entry[i-1]), .left_keep(cell_keep[i-1]),
                    .right_entry(cell_entry[i+1]),
                    .entry(cell_entry[i]), .keep(cell_keep[i])
                );
            end
        end
    endgenerate

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        otag_next    = otag_reg;
        opri_next    = opri_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_acc) begin
            m_valid_next = 1'b1;
            status_next  = spq_pkg::ST_DONE;
            otag_next    = '0;
            opri_next    = '0;
            if (cmd == spq_pkg::CMD_ENQ) begin
                if (full) begin
                    status_next = spq_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end else begin
                if (empty) begin
                    status_next = spq_pkg::ST_EMPTY;
                end else begin
                    otag_next  = cell_entry[0].tag;
                    opri_next  = cell_entry[0].pri;
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    logic [spq_pkg::OCC_W-1:0] occ_reg;
    logic [spq_pkg::OCC_W-1:0] occ_next;

    assign occ_next = s_acc ? count_next[spq_pkg::OCC_W-1:0] : occ_reg;

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        otag_reg   <= otag_next;
        opri_reg   <= opri_next;
        occ_reg    <= occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, occ_reg, opri_reg, otag_reg, status_reg};

endmodule

// ===== hw/rtl/spq_checker.sv =====
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [spq_pkg::M_DATA_W-1:0]  m_tdata
);

    logic [spq_pkg::STAT_W-1:0] st;
    logic [spq_pkg::OCC_W-1:0]  occ;

    assign st  = m_tdata[1:0];
    assign occ = m_tdata[32:26];

    // held result stays put while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty result register");

    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (st == spq_pkg::ST_DONE || st == spq_pkg::ST_EMPTY ||
                      st == spq_pkg::ST_FULL))
        else $error("bad status code");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == spq_pkg::ST_EMPTY |-> occ == '0 && m_tdata[25:2] == '0)
        else $error("empty refusal with data or entries");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == spq_pkg::ST_FULL |->
            occ == spq_pkg::OCC_W'(spq_pkg::DEPTH) && m_tdata[25:2] == '0)
        else $error("full refusal with wrong occupancy");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== bench/tb_sorted_priority_queue.sv =====
// testbench for the sorted priority queue: directed table, random phases, model check
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

    localparam int N_RANDOM    = 1350;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_ROWS      = 23;

    typedef enum int { PH_FILL, PH_DRAIN, PH_MIX } phase_t;

    typedef struct packed {
        logic [spq_pkg::STAT_W-1:0]       status;
        logic [spq_pkg::TAG_W-1:0]        tag;
        logic signed [spq_pkg::PRI_W-1:0] pri;
        logic [spq_pkg::OCC_W-1:0]        occ;
    } result_t;

    typedef struct packed {
        logic                             cmd;
        logic [spq_pkg::TAG_W-1:0]        tag;
        logic signed [spq_pkg::PRI_W-1:0] pri;
        logic                             fixed;
        result_t                          want;
    } row_t;

    localparam result_t NONE = '0;

    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        '{spq_pkg::CMD_DEQ, 8'h00, 16'sh0000, 1'b1,
          '{spq_pkg::ST_EMPTY, 8'h00, 16'sh0000, 7'd0}},
        '{spq_pkg::CMD_ENQ, 8'h00, 16'sh8000, 1'b1,
          '{spq_pkg::ST_DONE,  8'h00, 16'sh0000, 7'd1}},
        '{spq_pkg::CMD_ENQ, 8'hFF, 16'sh7FFF, 1'b1,
          '{spq_pkg::ST_DONE,  8'h00, 16'sh0000, 7'd2}},
        '{spq_pkg::CMD_ENQ, 8'h5A, 16'sh0000, 1'b1,
          '{spq_pkg::ST_DONE,  8'h00, 16'sh0000, 7'd3}},
        '{spq_pkg::CMD_ENQ, 8'hA5, 16'sh0000, 1'b1,
          '{spq_pkg::ST_DONE,  8'h00, 16'sh0000, 7'd4}},
        '{spq_pkg::CMD_ENQ, 8'h33, 16'shFFFF, 1'b1,
          '{spq_pkg::ST_DONE,  8'h00, 16'sh0000, 7'd5}},
        '{spq_pkg::CMD_DEQ, 8'hFF, 16'sh7FFF, 1'b1,
          '{spq_pkg::ST_DONE,  8'h00, 16'sh8000, 7'd4}},
        '{spq_pkg::CMD_DEQ, 8'hAA, 16'sh5555, 1'b0, NONE},
        '{spq_pkg::CMD_DEQ, 8'h55, 16'shAAAA, 1'b0, NONE},
        '{spq_pkg::CMD_DEQ, 8'h00, 16'sh0000, 1'b0, NONE},
        '{spq_pkg::CMD_DEQ, 8'h00, 16'sh0000, 1'b1,
          '{spq_pkg::ST_DONE,  8'hFF, 16'sh7FFF, 7'd0}},
        '{spq_pkg::CMD_DEQ, 8'hFF, 16'shFFFF, 1'b1,
          '{spq_pkg::ST_EMPTY, 8'h00, 16'sh0000, 7'd0}},
        '{spq_pkg::CMD_ENQ, 8'h81, 16'sh7FFF, 1'b0, NONE},
        '{spq_pkg::CMD_ENQ, 8'h7E, 16'sh7FFF, 1'b0, NONE},
        '{spq_pkg::CMD_ENQ, 8'h01, 16'sh8000, 1'b0, NONE},
        '{spq_pkg::CMD_ENQ, 8'hC3, 16'sh8001, 1'b0, NONE},
        '{spq_pkg::CMD_ENQ, 8'h3C, 16'sh0001, 1'b0, NONE},
        '{spq_pkg::CMD_DEQ, 8'h00, 16'sh0000, 1'b0, NONE},
        '{spq_pkg::CMD_DEQ, 8'h00, 16'sh0000, 1'b0, NONE},
        '{spq_pkg::CMD_DEQ, 8'h00, 16'sh0000, 1'b0, NONE},
        '{spq_pkg::CMD_DEQ, 8'h00, 16'sh0000, 1'b0, NONE},
        '{spq_pkg::CMD_DEQ, 8'h00, 16'sh0000, 1'b0, NONE},
        '{spq_pkg::CMD_DEQ, 8'h00, 16'sh0000, 1'b1,
          '{spq_pkg::ST_EMPTY, 8'h00, 16'sh0000, 7'd0}}
    };

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [spq_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [spq_pkg::M_DATA_W-1:0] m_tdata;

    logic [spq_pkg::TAG_W-1:0]        held_tag [spq_pkg::DEPTH];
    logic signed [spq_pkg::PRI_W-1:0] held_pri [spq_pkg::DEPTH];
    int                               held_n;

    result_t pending_results [$];
    row_t    sent_requests   [$];

    bit tx_idle     = 1'b0;
    bit rx_stall_on = 1'b0;
    int cycles      = 0;
    int errors      = 0;
    int n_enq       = 0;
    int n_deq       = 0;
    int n_full      = 0;
    int n_empty     = 0;
    int peak_occ    = 0;
    int n_results   = 0;

    sorted_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic result_t queue_apply(logic cmd, logic [spq_pkg::TAG_W-1:0] t,
                                            logic signed [spq_pkg::PRI_W-1:0] p);
        result_t r;
        int      pos;
        int      k;
        r = '0;
        r.status = spq_pkg::ST_DONE;
        if (cmd == spq_pkg::CMD_ENQ) begin
            if (held_n >= spq_pkg::DEPTH) begin
                r.status = spq_pkg::ST_FULL;
                n_full++;
            end else begin
                pos = 0;
                while (pos < held_n && held_pri[pos] <= p)
                    pos++;
                for (k = held_n; k > pos; k--) begin
                    held_tag[k] = held_tag[k-1];
                    held_pri[k] = held_pri[k-1];
                end
                held_tag[pos] = t;
                held_pri[pos] = p;
                held_n++;
                n_enq++;
            end
        end else begin
            if (held_n == 0) begin
                r.status = spq_pkg::ST_EMPTY;
                n_empty++;
            end else begin
                r.tag = held_tag[0];
                r.pri = held_pri[0];
                for (k = 1; k < held_n; k++) begin
                    held_tag[k-1] = held_tag[k];
                    held_pri[k-1] = held_pri[k];
                end
                held_n--;
                n_deq++;
            end
        end
        if (held_n > peak_occ)
            peak_occ = held_n;
        r.occ = spq_pkg::OCC_W'(held_n);
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        errors++;
        $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
                 $time, n_results, field, got, want);
    endtask

    task automatic compare_result(result_t got, result_t want);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.tag !== want.tag)
            report_mismatch("out_tag", got.tag, want.tag);
        if (got.pri !== want.pri)
            report_mismatch("out_priority", got.pri, want.pri);
        if (got.occ !== want.occ)
            report_mismatch("occupancy", got.occ, want.occ);
    endtask

    // check results first, then log the request taken at this edge
    always @(posedge aclk) begin
        result_t got;
        row_t    rq;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.tag    = m_tdata[9:2];
                got.pri    = m_tdata[25:10];
                got.occ    = m_tdata[32:26];
                n_results++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("[%0t] result with no request outstanding", $time);
                end else begin
                    compare_result(got, pending_results.pop_front());
                end
            end
            if (s_tvalid && s_tready) begin
                rq = sent_requests.pop_front();
                got = queue_apply(s_tdata[0], s_tdata[8:1], s_tdata[24:9]);
                pending_results.push_back(rq.fixed ? rq.want : got);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int stall;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            stall = rx_stall_on ? $urandom_range(0, 18) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_request(row_t rq);
        int gap;
        gap = tx_idle ? $urandom_range(0, 18) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        sent_requests.push_back(rq);
        s_tdata  = {7'b0, rq.pri, rq.tag, rq.cmd};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic signed [spq_pkg::PRI_W-1:0] pick_priority(int style);
        logic signed [spq_pkg::PRI_W-1:0] corner [7];
        corner = '{16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000, 16'sh0001,
                   16'sh7FFE, 16'sh7FFF};
        case (style)
            0: return spq_pkg::PRI_W'($urandom);
            1: return spq_pkg::PRI_W'($urandom_range(0, 6) - 3);
            default: return corner[$urandom_range(0, 6)];
        endcase
    endfunction

    initial begin
        row_t   rq;
        phase_t kind;
        int     sent;
        int     phase_no;
        int     len;
        int     enq_pct;
        int     style;
        held_n = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        tx_idle     = 1'b1;
        rx_stall_on = 1'b1;
        foreach (DIRECTED_ROWS[i])
            send_request(DIRECTED_ROWS[i]);
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait_drained();

        sent     = 0;
        phase_no = 0;
        while (sent < N_RANDOM) begin
            if (phase_no < 2)
                kind = (phase_no == 0) ? PH_FILL : PH_DRAIN;
            else
                kind = phase_t'($urandom_range(0, 2));
            case (kind)
                PH_FILL: begin
                    len = $urandom_range(70, 110);
                    enq_pct = 90;
                end
                PH_DRAIN: begin
                    len = $urandom_range(70, 110);
                    enq_pct = 10;
                end
                default: begin
                    len = $urandom_range(20, 80);
                    enq_pct = 50;
                end
            endcase
            style       = $urandom_range(0, 2);
            tx_idle     = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            repeat (len) begin
                rq.cmd   = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::CMD_ENQ
                                                                : spq_pkg::CMD_DEQ;
                rq.tag   = spq_pkg::TAG_W'($urandom_range(0, 255));
                rq.pri   = pick_priority(style);
                rq.fixed = 1'b0;
                rq.want  = '0;
                send_request(rq);
                sent++;
            end
            // hold further requests until the queue's answers are all back
            if (phase_no == 1 || $urandom_range(0, 3) == 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                wait_drained();
            end
            phase_no++;
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("%0d requests over %0d phases: %0d enqueued, %0d dequeued, peak occupancy %0d",
                 N_ROWS + sent, phase_no, n_enq, n_deq, peak_occ);
        $display("refusals: %0d full, %0d empty; %0d results checked, %0d mismatches",
                 n_full, n_empty, n_results, errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
